>>> sv/cpvl_pkg.sv
// ----------------------------------------------------------------------------
// cpvl_pkg
// Shared types, widths and constants for the Cartesian P velocity limiter.
// ----------------------------------------------------------------------------
package cpvl_pkg;

	// Field widths
	localparam int POS_W   = 24;  // Q3.20 position / velocity
	localparam int ERR_W   = 25;  // target - now, exact
	localparam int COEF_W  = 16;  // Q1.14 rotation coefficient
	localparam int GAIN_W  = 16;  // Q8.8 unsigned gain
	localparam int LIM_W   = 23;  // unsigned Q3.20 limit
	localparam int CFG_W   = 48;  // widest config register
	localparam int ACC_W   = 43;  // sum of three coef * err products
	localparam int R_W     = 29;  // rotated error after >> 14
	localparam int MUL_A_W = 29;  // shared multiplier, operand a
	localparam int MUL_B_W = 17;  // shared multiplier, operand b
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int VF_W    = PROD_W - 8;  // product after >> 8
	localparam int AXES    = 3;

	// Rounding offsets (half an LSB after the shift)
	localparam logic signed [ACC_W-1:0]  ROT_HALF  = ACC_W'(8192);
	localparam logic signed [PROD_W-1:0] GAIN_HALF = PROD_W'(128);

	// Speed saturation bounds
	localparam logic signed [VF_W-1:0] SPD_MAX = VF_W'(64'sd8388607);
	localparam logic signed [VF_W-1:0] SPD_MIN = VF_W'(-64'sd8388608);

	// Limit reset value: 0.3 m/s
	localparam logic [LIM_W-1:0] SPEED_RESET = LIM_W'(314573);

	// Work queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_ROT_ROW0    = 3'd0,
		REG_ROT_ROW1    = 3'd1,
		REG_ROT_ROW2    = 3'd2,
		REG_AXIS_GAINS  = 3'd3,
		REG_MAX_SPEED_X = 3'd4,
		REG_MAX_SPEED_Y = 3'd5,
		REG_MAX_SPEED_Z = 3'd6
	} cfg_reg_t;

	// Position error word passed through the queue
	typedef struct packed {
		logic signed [ERR_W-1:0] ex;
		logic signed [ERR_W-1:0] ey;
		logic signed [ERR_W-1:0] ez;
	} err_t;

	// Configuration snapshot seen by the back end
	typedef struct packed {
		logic [CFG_W-1:0] rot_row0;
		logic [CFG_W-1:0] rot_row1;
		logic [CFG_W-1:0] rot_row2;
		logic [CFG_W-1:0] axis_gains;
		logic [LIM_W-1:0] max_speed_x;
		logic [LIM_W-1:0] max_speed_y;
		logic [LIM_W-1:0] max_speed_z;
	} cfg_t;

	// Result word
	typedef struct packed {
		logic signed [POS_W-1:0] speed_x;
		logic signed [POS_W-1:0] speed_y;
		logic signed [POS_W-1:0] speed_z;
		logic [AXES-1:0]         held_mask;
	} res_t;

	// Back-end sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_RND,
		ST_GMUL,
		ST_LIM,
		ST_DONE
	} bk_state_t;

	// Saturate a rounded speed to 24 bits
	function automatic logic signed [POS_W-1:0] sat_speed(input logic signed [VF_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if (v > SPD_MAX)
			r = SPD_MAX[POS_W-1:0];
		else if (v < SPD_MIN)
			r = SPD_MIN[POS_W-1:0];
		else
			r = v[POS_W-1:0];
		return r;
	endfunction

	// Clamp a stored speed to +/- limit
	function automatic logic signed [POS_W-1:0] clamp_speed(
		input logic signed [POS_W-1:0] s,
		input logic [LIM_W-1:0]        lim
	);
		logic signed [POS_W:0] s_w;
		logic signed [POS_W:0] hi;
		logic signed [POS_W:0] lo;
		logic signed [POS_W:0] r;
		s_w = {s[POS_W-1], s};
		hi  = {2'b00, lim};
		lo  = -hi;
		if (s_w > hi)
			r = hi;
		else if (s_w < lo)
			r = lo;
		else
			r = s_w;
		return r[POS_W-1:0];
	endfunction

endpackage

>>> sv/cartesian_p_velocity_limiter.sv
// ----------------------------------------------------------------------------
// cartesian_p_velocity_limiter
// Proportional Cartesian velocity command with per-axis speed limit.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one word carries target and measured
// positions, Q3.20. The front end takes it and pushes the error into a
// two-entry queue; in_stall rises only while that queue is full.
// Output channel (out_valid / out_stall): one word per input, arm-frame
// speeds in Q3.20 and a held mask, bit per axis.
// The back end works one word at a time: per axis it runs three rotation
// multiplies, a round, a gain multiply and a limit step on one shared
// 29x17 multiplier, plus load and hand-off, and takes no new word until
// the last is handed off; this loop sets the throughput.
// A finished word waits in the output register while out_stall is high;
// the back end holds its next result until that register frees, and the
// front end keeps filling the queue meanwhile.
// Reset clears the queue and the previous speeds, sets rotation and gains
// to zero and all three limits to 0.3 m/s. Configuration is written through
// cfg_we / cfg_index / cfg_data, by the user only while the block is idle;
// the block does not enforce this. Unused indexes are ignored.
// ----------------------------------------------------------------------------
module cartesian_p_velocity_limiter (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [2:0]                        cfg_index,
	input  logic [cpvl_pkg::CFG_W-1:0]        cfg_data,
	// input words
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [cpvl_pkg::POS_W-1:0] target_x,
	input  logic signed [cpvl_pkg::POS_W-1:0] target_y,
	input  logic signed [cpvl_pkg::POS_W-1:0] target_z,
	input  logic signed [cpvl_pkg::POS_W-1:0] now_x,
	input  logic signed [cpvl_pkg::POS_W-1:0] now_y,
	input  logic signed [cpvl_pkg::POS_W-1:0] now_z,
	// output words
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [cpvl_pkg::POS_W-1:0] speed_x,
	output logic signed [cpvl_pkg::POS_W-1:0] speed_y,
	output logic signed [cpvl_pkg::POS_W-1:0] speed_z,
	output logic [cpvl_pkg::AXES-1:0]         held_mask
);

	cpvl_pkg::cfg_t  cfg_q;
	cpvl_pkg::err_t  push_data;
	cpvl_pkg::err_t  head;
	cpvl_pkg::res_t  res;
	cpvl_pkg::res_t  out_q;
	logic            push;
	logic            pop;
	logic            q_full;
	logic            head_valid;
	logic            slot_free;
	logic            res_load;
	logic            out_valid_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot_row0    <= '0;
			cfg_q.rot_row1    <= '0;
			cfg_q.rot_row2    <= '0;
			cfg_q.axis_gains  <= '0;
			cfg_q.max_speed_x <= cpvl_pkg::SPEED_RESET;
			cfg_q.max_speed_y <= cpvl_pkg::SPEED_RESET;
			cfg_q.max_speed_z <= cpvl_pkg::SPEED_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cpvl_pkg::REG_ROT_ROW0:    cfg_q.rot_row0    <= cfg_data;
				cpvl_pkg::REG_ROT_ROW1:    cfg_q.rot_row1    <= cfg_data;
				cpvl_pkg::REG_ROT_ROW2:    cfg_q.rot_row2    <= cfg_data;
				cpvl_pkg::REG_AXIS_GAINS:  cfg_q.axis_gains  <= cfg_data;
				cpvl_pkg::REG_MAX_SPEED_X: cfg_q.max_speed_x <= cfg_data[cpvl_pkg::LIM_W-1:0];
				cpvl_pkg::REG_MAX_SPEED_Y: cfg_q.max_speed_y <= cfg_data[cpvl_pkg::LIM_W-1:0];
				cpvl_pkg::REG_MAX_SPEED_Z: cfg_q.max_speed_z <= cfg_data[cpvl_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Front end: error and queue push
	cpvl_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.target_x (target_x),
		.target_y (target_y),
		.target_z (target_z),
		.now_x    (now_x),
		.now_y    (now_y),
		.now_z    (now_z),
		.q_full   (q_full),
		.q_push   (push),
		.q_data   (push_data)
	);

	// Work queue
	cpvl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	// Back end: rotation, gain, limit
	cpvl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (head_valid),
		.q_head    (head),
		.q_pop     (pop),
		.slot_free (slot_free),
		.res_load  (res_load),
		.res       (res)
	);

	// Output register
	assign slot_free = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load)
			out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign speed_x   = out_q.speed_x;
	assign speed_y   = out_q.speed_y;
	assign speed_z   = out_q.speed_z;
	assign held_mask = out_q.held_mask;

endmodule

>>> sv/cpvl_front.sv
// ----------------------------------------------------------------------------
// cpvl_front
// Input side: takes a position word, forms the base-frame error and
// pushes it into the work queue.
// ----------------------------------------------------------------------------
module cpvl_front (
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [cpvl_pkg::POS_W-1:0]  target_x,
	input  logic signed [cpvl_pkg::POS_W-1:0]  target_y,
	input  logic signed [cpvl_pkg::POS_W-1:0]  target_z,
	input  logic signed [cpvl_pkg::POS_W-1:0]  now_x,
	input  logic signed [cpvl_pkg::POS_W-1:0]  now_y,
	input  logic signed [cpvl_pkg::POS_W-1:0]  now_z,
	input  logic                               q_full,
	output logic                               q_push,
	output cpvl_pkg::err_t                     q_data
);

	// Hold off the sender while the queue is full
	assign in_stall = q_full;
	assign q_push   = in_valid & ~q_full;

	// Exact 25-bit error per axis
	always_comb begin
		q_data.ex = {target_x[cpvl_pkg::POS_W-1], target_x} - {now_x[cpvl_pkg::POS_W-1], now_x};
		q_data.ey = {target_y[cpvl_pkg::POS_W-1], target_y} - {now_y[cpvl_pkg::POS_W-1], now_y};
		q_data.ez = {target_z[cpvl_pkg::POS_W-1], target_z} - {now_z[cpvl_pkg::POS_W-1], now_z};
	end

endmodule

>>> sv/cpvl_queue.sv
// ----------------------------------------------------------------------------
// cpvl_queue
// Two-entry queue of error words between the front and back ends.
// ----------------------------------------------------------------------------
module cpvl_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cpvl_pkg::err_t push_data,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output cpvl_pkg::err_t head
);

	cpvl_pkg::err_t                  mem_q [cpvl_pkg::QDEPTH];
	logic [cpvl_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [cpvl_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [cpvl_pkg::QCNT_W-1:0]     count_q;

	assign full       = (count_q == cpvl_pkg::QCNT_W'(cpvl_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

>>> sv/cpvl_back.sv
// ----------------------------------------------------------------------------
// cpvl_back
// Compute sequencer: rotation, gain and limit on one shared 29x17
// multiplier, one axis at a time. Holds the previous speeds.
// ----------------------------------------------------------------------------
module cpvl_back (
	input  logic           clk,
	input  logic           arst_n,
	input  cpvl_pkg::cfg_t cfg,
	input  logic           q_valid,
	input  cpvl_pkg::err_t q_head,
	output logic           q_pop,
	input  logic           slot_free,
	output logic           res_load,
	output cpvl_pkg::res_t res
);

	cpvl_pkg::bk_state_t state_q, state_d;

	logic [1:0] axis_q;
	logic [1:0] step_q;

	cpvl_pkg::err_t                            err_q;
	logic signed [cpvl_pkg::ACC_W-1:0]         acc_q;
	logic signed [cpvl_pkg::PROD_W-1:0]        prod_q;
	logic signed [cpvl_pkg::R_W-1:0]           r_q;
	logic signed [cpvl_pkg::POS_W-1:0]         last_q [cpvl_pkg::AXES];
	logic signed [cpvl_pkg::POS_W-1:0]         vres_q [cpvl_pkg::AXES];
	logic [cpvl_pkg::AXES-1:0]                 held_q;

	logic [cpvl_pkg::CFG_W-1:0]                row;
	logic signed [cpvl_pkg::COEF_W-1:0]        coef;
	logic signed [cpvl_pkg::ERR_W-1:0]         e_sel;
	logic [cpvl_pkg::GAIN_W-1:0]               gain;
	logic [cpvl_pkg::LIM_W-1:0]                lim;
	logic signed [cpvl_pkg::MUL_A_W-1:0]       mul_a;
	logic signed [cpvl_pkg::MUL_B_W-1:0]       mul_b;
	logic signed [cpvl_pkg::PROD_W-1:0]        mul_p;
	logic signed [cpvl_pkg::ACC_W-1:0]         acc_sum;
	logic signed [cpvl_pkg::PROD_W-1:0]        v_rnd;
	logic signed [cpvl_pkg::POS_W-1:0]         v_sat;
	logic signed [cpvl_pkg::POS_W:0]           v_mag;
	logic                                      over;
	logic signed [cpvl_pkg::POS_W-1:0]         v_out;

	// Per-axis operand selection
	always_comb begin
		unique case (axis_q)
			2'd0: begin
				row  = cfg.rot_row0;
				gain = cfg.axis_gains[15:0];
				lim  = cfg.max_speed_x;
			end
			2'd1: begin
				row  = cfg.rot_row1;
				gain = cfg.axis_gains[31:16];
				lim  = cfg.max_speed_y;
			end
			default: begin
				row  = cfg.rot_row2;
				gain = cfg.axis_gains[47:32];
				lim  = cfg.max_speed_z;
			end
		endcase
		unique case (step_q)
			2'd0: begin
				coef  = row[15:0];
				e_sel = err_q.ex;
			end
			2'd1: begin
				coef  = row[31:16];
				e_sel = err_q.ey;
			end
			default: begin
				coef  = row[47:32];
				e_sel = err_q.ez;
			end
		endcase
	end

	// Shared multiplier: coef * err during the rotation, r * gain after it
	always_comb begin
		if (state_q == cpvl_pkg::ST_GMUL) begin
			mul_a = r_q;
			mul_b = {1'b0, gain};
		end else begin
			mul_a = {{(cpvl_pkg::MUL_A_W - cpvl_pkg::ERR_W){e_sel[cpvl_pkg::ERR_W-1]}}, e_sel};
			mul_b = {coef[cpvl_pkg::COEF_W-1], coef};
		end
	end
	assign mul_p = mul_a * mul_b;

	// Accumulate; the rounding half is preloaded into the accumulator
	assign acc_sum = acc_q + prod_q[cpvl_pkg::ACC_W-1:0];

	// Gain rounding, saturation and limit test
	always_comb begin
		v_rnd = prod_q + cpvl_pkg::GAIN_HALF;
		v_sat = cpvl_pkg::sat_speed(v_rnd[cpvl_pkg::PROD_W-1:8]);
		v_mag = v_sat[cpvl_pkg::POS_W-1] ? -{v_sat[cpvl_pkg::POS_W-1], v_sat}
		                                 : {v_sat[cpvl_pkg::POS_W-1], v_sat};
		over  = (v_mag > {2'b00, lim});
		v_out = over ? cpvl_pkg::clamp_speed(last_q[axis_q], lim) : v_sat;
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= cpvl_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and handshake outputs
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			cpvl_pkg::ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = cpvl_pkg::ST_MAC;
				end
			end
			cpvl_pkg::ST_MAC: begin
				if (step_q == 2'd2)
					state_d = cpvl_pkg::ST_RND;
			end
			cpvl_pkg::ST_RND:  state_d = cpvl_pkg::ST_GMUL;
			cpvl_pkg::ST_GMUL: state_d = cpvl_pkg::ST_LIM;
			cpvl_pkg::ST_LIM: begin
				if (axis_q == 2'd2)
					state_d = cpvl_pkg::ST_DONE;
				else
					state_d = cpvl_pkg::ST_MAC;
			end
			cpvl_pkg::ST_DONE: begin
				if (slot_free) begin
					res_load = 1'b1;
					state_d  = cpvl_pkg::ST_IDLE;
				end
			end
			default: state_d = cpvl_pkg::ST_IDLE;
		endcase
	end

	// Axis and step counters, previous speeds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= '0;
			step_q <= '0;
			for (int i = 0; i < cpvl_pkg::AXES; i++)
				last_q[i] <= '0;
		end else begin
			unique case (state_q)
				cpvl_pkg::ST_IDLE: begin
					axis_q <= '0;
					step_q <= '0;
				end
				cpvl_pkg::ST_MAC: begin
					if (step_q != 2'd2)
						step_q <= step_q + 1'b1;
				end
				cpvl_pkg::ST_LIM: begin
					last_q[axis_q] <= v_out;
					axis_q         <= axis_q + 1'b1;
					step_q         <= '0;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			cpvl_pkg::ST_IDLE: begin
				if (q_valid)
					err_q <= q_head;
			end
			cpvl_pkg::ST_MAC: begin
				prod_q <= mul_p;
				acc_q  <= (step_q == 2'd0) ? cpvl_pkg::ROT_HALF : acc_sum;
			end
			cpvl_pkg::ST_RND: begin
				r_q <= acc_sum[cpvl_pkg::ACC_W-1:14];
			end
			cpvl_pkg::ST_GMUL: begin
				prod_q <= mul_p;
			end
			cpvl_pkg::ST_LIM: begin
				vres_q[axis_q] <= v_out;
				held_q[axis_q] <= over;
			end
			default: ;
		endcase
	end

	// Result word
	always_comb begin
		res.speed_x   = vres_q[0];
		res.speed_y   = vres_q[1];
		res.speed_z   = vres_q[2];
		res.held_mask = held_q;
	end

endmodule

>>> dv/cpvl_speed_checker.sv
// ----------------------------------------------------------------------------
// cpvl_speed_checker
// Watches the configuration port and both word channels of the velocity
// limiter, predicts each result word from the accepted input words and
// compares the result words against those predictions in order.
// ----------------------------------------------------------------------------
module cpvl_speed_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [2:0]                        cfg_index,
	input  logic [cpvl_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic signed [cpvl_pkg::POS_W-1:0] target_x,
	input  logic signed [cpvl_pkg::POS_W-1:0] target_y,
	input  logic signed [cpvl_pkg::POS_W-1:0] target_z,
	input  logic signed [cpvl_pkg::POS_W-1:0] now_x,
	input  logic signed [cpvl_pkg::POS_W-1:0] now_y,
	input  logic signed [cpvl_pkg::POS_W-1:0] now_z,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [cpvl_pkg::POS_W-1:0] speed_x,
	input  logic signed [cpvl_pkg::POS_W-1:0] speed_y,
	input  logic signed [cpvl_pkg::POS_W-1:0] speed_z,
	input  logic [cpvl_pkg::AXES-1:0]         held_mask,
	output int                                fail_count,
	output int                                pending
);
	import cpvl_pkg::*;

	localparam int ROT_FRAC    = 14;
	localparam int GAIN_FRAC   = 8;

	// shadow of the configuration and the stored speeds
	logic [CFG_W-1:0]        rot_row [AXES];
	logic [CFG_W-1:0]        gain_word;
	logic [LIM_W-1:0]        speed_limit [AXES];
	logic signed [POS_W-1:0] prev_speed [AXES];
	res_t                    speed_fifo [$];
	int                      mismatches = 0;

	// error -> rotate -> gain -> saturate -> limit, updates stored speeds
	function automatic res_t predict_speeds(
		input logic signed [POS_W-1:0] tx,
		input logic signed [POS_W-1:0] ty,
		input logic signed [POS_W-1:0] tz,
		input logic signed [POS_W-1:0] nx,
		input logic signed [POS_W-1:0] ny,
		input logic signed [POS_W-1:0] nz
	);
		longint                  err [AXES];
		longint                  acc;
		longint                  v;
		longint                  lim;
		logic signed [POS_W-1:0] axis_speed [AXES];
		logic [AXES-1:0]         held;
		res_t                    res;
		int                      i;
		int                      j;
		err[0] = longint'(tx) - longint'(nx);
		err[1] = longint'(ty) - longint'(ny);
		err[2] = longint'(tz) - longint'(nz);
		held = '0;
		for (i = 0; i < AXES; i++) begin
			acc = 0;
			for (j = 0; j < AXES; j++)
				acc += longint'($signed(rot_row[i][COEF_W*j +: COEF_W])) * err[j];
			// round half up: arithmetic shift of value plus half an LSB
			acc = (acc + (longint'(1) <<< (ROT_FRAC - 1))) >>> ROT_FRAC;
			v = acc * longint'(gain_word[GAIN_W*i +: GAIN_W]);
			v = (v + (longint'(1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
			if (v > longint'(SPD_MAX))
				v = longint'(SPD_MAX);
			else if (v < longint'(SPD_MIN))
				v = longint'(SPD_MIN);
			// over the limit: reuse the previous speed, clamped
			lim = longint'(speed_limit[i]);
			if ((v < 0 ? -v : v) > lim) begin
				v = longint'(prev_speed[i]);
				if (v > lim)
					v = lim;
				else if (v < -lim)
					v = -lim;
				held[i] = 1'b1;
			end
			axis_speed[i] = v[POS_W-1:0];
			prev_speed[i] = axis_speed[i];
		end
		res.speed_x   = axis_speed[0];
		res.speed_y   = axis_speed[1];
		res.speed_z   = axis_speed[2];
		res.held_mask = held;
		return res;
	endfunction

	function automatic void check_field(input string field, input longint want,
			input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			mismatches++;
		end
	endfunction

	// sample both channels at the clock edge
	always @(posedge clk) begin
		res_t want;
		if (!arst_n) begin
			rot_row[0]     = '0;
			rot_row[1]     = '0;
			rot_row[2]     = '0;
			gain_word      = '0;
			speed_limit[0] = SPEED_RESET;
			speed_limit[1] = SPEED_RESET;
			speed_limit[2] = SPEED_RESET;
			prev_speed[0]  = '0;
			prev_speed[1]  = '0;
			prev_speed[2]  = '0;
			speed_fifo.delete();
		end else begin
			// register writes keep only the register width
			if (cfg_we) begin
				case (cfg_index)
					REG_ROT_ROW0:    rot_row[0] = cfg_data;
					REG_ROT_ROW1:    rot_row[1] = cfg_data;
					REG_ROT_ROW2:    rot_row[2] = cfg_data;
					REG_AXIS_GAINS:  gain_word = cfg_data;
					REG_MAX_SPEED_X: speed_limit[0] = cfg_data[LIM_W-1:0];
					REG_MAX_SPEED_Y: speed_limit[1] = cfg_data[LIM_W-1:0];
					REG_MAX_SPEED_Z: speed_limit[2] = cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end
			// result word against the oldest prediction
			if (out_valid && !out_stall) begin
				if (speed_fifo.size() == 0) begin
					$display("%0t: result word with nothing expected, got %0d %0d %0d mask %0b",
						$time, speed_x, speed_y, speed_z, held_mask);
					mismatches++;
				end else begin
					want = speed_fifo.pop_front();
					check_field("speed_x", $signed(want.speed_x), speed_x);
					check_field("speed_y", $signed(want.speed_y), speed_y);
					check_field("speed_z", $signed(want.speed_z), speed_z);
					check_field("held_mask", want.held_mask, held_mask);
				end
			end
			if (in_valid && !in_stall)
				speed_fifo.insert(speed_fifo.size(), predict_speeds(target_x, target_y,
					target_z, now_x, now_y, now_z));
		end
		pending    <= speed_fifo.size();
		fail_count <= mismatches;
	end

endmodule

>>> dv/tb_cartesian_p_velocity_limiter.sv
// ----------------------------------------------------------------------------
// tb_cartesian_p_velocity_limiter
// Drives configuration settings and position words into the velocity
// limiter with random idling on both channels; a checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_cartesian_p_velocity_limiter;
	import cpvl_pkg::*;

	localparam int               HOLD_CYCLES    = 160;
	localparam int               WATCHDOG_LIMIT = 3000;
	localparam int               DRAIN_CYCLES   = 40;
	localparam int               PHASES         = 8;
	localparam int               PHASE_WORDS    = 112;
	localparam int               FILL_WORDS     = 30;
	localparam int               COEF_ONE       = 16384;
	localparam int               GAIN_ONE       = 256;
	localparam int               POS_MAX        = 8388607;
	localparam int               POS_MIN        = -8388608;
	localparam logic [2:0]       REG_UNUSED     = 3'd7;
	localparam logic [CFG_W-1:0] ROW_X          = CFG_W'(COEF_ONE);
	localparam logic [CFG_W-1:0] ROW_Y          = CFG_W'(COEF_ONE) << COEF_W;
	localparam logic [CFG_W-1:0] ROW_Z          = CFG_W'(COEF_ONE) << (2 * COEF_W);

	typedef enum {MIX_TUNED, MIX_RANDOM, MIX_EXTREME} setup_mix_t;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_we    = 1'b0;
	logic [2:0]              cfg_index = '0;
	logic [CFG_W-1:0]        cfg_data  = '0;
	logic                    in_valid  = 1'b0;
	logic                    in_stall;
	logic signed [POS_W-1:0] target_x  = '0;
	logic signed [POS_W-1:0] target_y  = '0;
	logic signed [POS_W-1:0] target_z  = '0;
	logic signed [POS_W-1:0] now_x     = '0;
	logic signed [POS_W-1:0] now_y     = '0;
	logic signed [POS_W-1:0] now_z     = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [POS_W-1:0] speed_x;
	logic signed [POS_W-1:0] speed_y;
	logic signed [POS_W-1:0] speed_z;
	logic [AXES-1:0]         held_mask;
	int                      fail_count;
	int                      pending;
	bit                      calm        = 1'b0;
	bit                      hold_go     = 1'b0;
	int                      idle_cycles = 0;

	cartesian_p_velocity_limiter u_dut (.*);

	cpvl_speed_checker u_checker (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	// three 16-bit fields, x in the low bits
	function automatic logic [CFG_W-1:0] pack3(input int a, input int b, input int c);
		return {16'(c), 16'(b), 16'(a)};
	endfunction

	function automatic int corner_coef();
		return ($urandom_range(0, 1) != 0) ? -32768 : 32767;
	endfunction

	// limit data with junk above the register width
	function automatic logic [CFG_W-1:0] rand_limit();
		logic [CFG_W-1:0] d;
		d = CFG_W'({$urandom, $urandom});
		case ($urandom_range(0, 4))
			0: d[LIM_W-1:0] = '0;
			1: d[LIM_W-1:0] = '1;
			2: ;
			default: d[LIM_W-1:0] = LIM_W'($urandom_range(0, 600000));
		endcase
		return d;
	endfunction

	// error of random magnitude, from one LSB up to about 1 m
	function automatic int rand_offset();
		int k;
		k = $urandom_range(0, 20);
		return int'($urandom_range(0, (2 << k) - 1)) - (1 << k);
	endfunction

	// all tasks start and end just after a rising edge
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// full register set, plus a write to the unused index that must be dropped
	task automatic load_setup(input logic [CFG_W-1:0] r0, input logic [CFG_W-1:0] r1,
			input logic [CFG_W-1:0] r2, input logic [CFG_W-1:0] gains,
			input logic [CFG_W-1:0] lx, input logic [CFG_W-1:0] ly,
			input logic [CFG_W-1:0] lz);
		settle();
		write_reg(REG_ROT_ROW0, r0);
		write_reg(REG_ROT_ROW1, r1);
		write_reg(REG_ROT_ROW2, r2);
		write_reg(REG_AXIS_GAINS, gains);
		write_reg(REG_MAX_SPEED_X, lx);
		write_reg(REG_MAX_SPEED_Y, ly);
		write_reg(REG_MAX_SPEED_Z, lz);
		write_reg(REG_UNUSED, CFG_W'({$urandom, $urandom}));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_word(input int tx, input int ty, input int tz,
			input int nx, input int ny, input int nz);
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		target_x <= POS_W'(tx);
		target_y <= POS_W'(ty);
		target_z <= POS_W'(tz);
		now_x    <= POS_W'(nx);
		now_y    <= POS_W'(ny);
		now_z    <= POS_W'(nz);
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_random();
		int tx;
		int ty;
		int tz;
		tx = int'($urandom);
		ty = int'($urandom);
		tz = int'($urandom);
		// mostly a measured pose near the target, sometimes anywhere
		if ($urandom_range(0, 3) != 0)
			send_word(tx, ty, tz, tx - rand_offset(), ty - rand_offset(), tz - rand_offset());
		else
			send_word(tx, ty, tz, int'($urandom), int'($urandom), int'($urandom));
	endtask

	task automatic random_setup(input setup_mix_t mix);
		logic [CFG_W-1:0] rows [AXES];
		logic [CFG_W-1:0] gains;
		int               i;
		case (mix)
			MIX_TUNED: begin
				// mounting rotation of the arm, modest gains
				rows[0] = pack3(-10281, 7199, -10532);
				rows[1] = pack3(-11321, 1086, 11793);
				rows[2] = pack3(5880, 14677, 4293);
				gains   = pack3($urandom_range(0, 1024), $urandom_range(0, 1024),
					$urandom_range(0, 1024));
			end
			MIX_RANDOM: begin
				for (i = 0; i < AXES; i++)
					rows[i] = CFG_W'({$urandom, $urandom});
				gains = CFG_W'({$urandom, $urandom});
			end
			default: begin
				for (i = 0; i < AXES; i++)
					rows[i] = pack3(corner_coef(), corner_coef(), corner_coef());
				gains = ($urandom_range(0, 1) != 0) ? '1 : CFG_W'({$urandom, $urandom});
			end
		endcase
		load_setup(rows[0], rows[1], rows[2], gains, rand_limit(), rand_limit(), rand_limit());
	endtask

	// receiver: random stall bursts, one long hold-off on request
	always begin
		if (hold_go) begin
			out_stall <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_go = 1'b0;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end else begin
			out_stall <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	// watchdog on cycles with no word or register moving
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("** cartesian_p_velocity_limiter: FAILED **");
			$finish;
		end else
			idle_cycles++;
	end

	initial begin
		int phase;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero rotation and gain give zero speed
		send_word(POS_MAX, POS_MIN, 12345, POS_MIN, POS_MAX, -1);
		send_word(0, 0, 0, 0, 0, 0);

		// unit rotation and gain, default limits
		load_setup(ROW_X, ROW_Y, ROW_Z, pack3(GAIN_ONE, GAIN_ONE, GAIN_ONE),
			SPEED_RESET, SPEED_RESET, SPEED_RESET);
		send_word(100000, -100000, 0, 0, 0, 0);
		send_word(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN);
		send_word(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX);
		// exactly at the limit passes, one above is held
		send_word(314573, -314573, 314574, 0, 0, 0);

		// rotation rounding at half an LSB
		load_setup(pack3(1, 0, 0), pack3(0, 1, 0), pack3(0, 0, 1),
			pack3(GAIN_ONE, GAIN_ONE, GAIN_ONE), SPEED_RESET, SPEED_RESET, SPEED_RESET);
		send_word(8192, -8192, -8193, 0, 0, 0);
		send_word(8191, -8191, 24576, 0, 0, 0);

		// gain rounding at half an LSB
		load_setup(ROW_X, ROW_Y, ROW_Z, pack3(1, 1, 1), SPEED_RESET, SPEED_RESET, SPEED_RESET);
		send_word(128, -128, -129, 0, 0, 0);
		send_word(127, 383, -127, 0, 0, 0);

		// zero limits on x and y, full scale on z, junk above the limit width
		load_setup(ROW_X, ROW_Y, ROW_Z, pack3(GAIN_ONE, GAIN_ONE, GAIN_ONE),
			48'hFFFF_FF80_0000, '0, '1);
		send_word(0, 0, 0, 0, 0, 0);
		send_word(5, -5, POS_MIN, 0, 0, 0);
		send_word(1, 0, POS_MAX, 0, 0, 0);

		// store large speeds, then lower the limits so the held value clamps
		load_setup(ROW_X, ROW_Y, ROW_Z, pack3(GAIN_ONE, GAIN_ONE, GAIN_ONE),
			8000000, 8000000, 8000000);
		send_word(1000000, -1000000, 7000000, 0, 0, 0);
		load_setup(ROW_X, ROW_Y, ROW_Z, pack3(GAIN_ONE, GAIN_ONE, GAIN_ONE),
			500000, 500000, 500000);
		send_word(POS_MAX, POS_MIN, POS_MAX, POS_MIN, POS_MAX, POS_MIN);

		// extreme coefficients and gains
		load_setup(pack3(-32768, -32768, -32768), pack3(-32768, -32768, -32768),
			pack3(-32768, -32768, -32768), '1, '1, '1, '1);
		send_word(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN);
		send_word(1, 0, 0, 0, 0, 0);
		load_setup(pack3(32767, 32767, 32767), pack3(32767, -32768, 0),
			pack3(0, 0, 32767), '1, '1, '1, 1);
		send_word(POS_MIN, POS_MAX, POS_MIN, POS_MAX, POS_MIN, POS_MAX);
		send_word(-3, 2, 1, 0, 0, 0);

		// random settings and words
		for (phase = 0; phase < PHASES; phase++) begin
			random_setup(setup_mix_t'(phase % 3));
			if (phase == 2) begin
				// receiver holds off while words keep coming
				hold_go = 1'b1;
				repeat (FILL_WORDS) send_random();
			end
			if (phase == PHASES - 1)
				calm = 1'b1;
			repeat (PHASE_WORDS) send_random();
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("** cartesian_p_velocity_limiter: PASSED **");
		else
			$display("** cartesian_p_velocity_limiter: FAILED **");
		$finish;
	end

endmodule
